[hdl/maze_cell_explorer_unit_defines.svh]
// Assertion macros shared by the maze cell explorer RTL.
`ifndef MAZE_CELL_EXPLORER_UNIT_DEFINES_SVH
`define MAZE_CELL_EXPLORER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CMEX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CMEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cmex_pkg.sv]
// Package with types, constants and helpers of the maze cell explorer.
`timescale 1ns / 1ps

package cmex_pkg;

	localparam int GRID_W = 8;
	localparam int GRID_H = 8;
	localparam int USE_W = (GRID_W < 8) ? GRID_W : 8;
	localparam int USE_H = (GRID_H < 8) ? GRID_H : 8;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int CELL_W = 9;
	localparam int VIS_BIT = 0;
	localparam int SIDE_LSB = 1;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [11:0] dist_t;
	typedef logic [2:0] coord_t;
	typedef logic [1:0] head_t;
	typedef logic [1:0] side_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [CELL_AW-1:0] cidx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		MOVE_FWD   = 3'd0,
		MOVE_RIGHT = 3'd1,
		MOVE_LEFT  = 3'd2,
		MOVE_BACK  = 3'd3,
		MOVE_NONE  = 3'd4
	} move_t;

	typedef enum logic [1:0] {
		REG_THRESH  = 2'd0,
		REG_START_X = 2'd1,
		REG_START_Y = 2'd2,
		REG_START_H = 2'd3
	} reg_idx_t;

	localparam side_t SIDE_WALL = 2'd0;
	localparam side_t SIDE_GAP  = 2'd1;
	localparam side_t SIDE_USED = 2'd2;

	localparam head_t DIR_N = 2'd0;
	localparam head_t DIR_E = 2'd1;
	localparam head_t DIR_S = 2'd2;
	localparam head_t DIR_W = 2'd3;

	localparam head_t REL_FWD   = 2'd0;
	localparam head_t REL_RIGHT = 2'd1;
	localparam head_t REL_BACK  = 2'd2;
	localparam head_t REL_LEFT  = 2'd3;
	localparam head_t REL_ORDER [4] = '{REL_FWD, REL_RIGHT, REL_LEFT, REL_BACK};

	localparam dist_t THRESH_RST = 12'd135;
	localparam int START_X_RST = 3;
	localparam int START_Y_RST = 4;
	localparam head_t START_H_RST = DIR_N;
	localparam coord_t POS_X_RST = coord_t'((START_X_RST < USE_W) ? START_X_RST : USE_W - 1);
	localparam coord_t POS_Y_RST = coord_t'((START_Y_RST < USE_H) ? START_Y_RST : USE_H - 1);

	typedef struct packed {
		dist_t  thresh;
		logic   ld_x;
		logic   ld_y;
		logic   ld_h;
		coord_t x;
		coord_t y;
		head_t  heading;
	} cfg_t;

	typedef struct packed {
		cell_t  cell_nxt;
		move_t  move;
		coord_t x;
		coord_t y;
		head_t  heading;
		logic   was_new;
		logic   blocked;
	} step_t;

	function automatic cidx_t cell_idx(input coord_t x, input coord_t y);
		int sum;
		sum = int'(y) * GRID_W + int'(x);
		return cidx_t'(sum);
	endfunction

endpackage

[hdl/maze_cell_explorer_unit.sv]
// Top level of the maze cell explorer: request register, cell store and result register.
// A request is held in the request register until it is processed, and its result in the result register.
// Throughput: one request per cycle unless out_stall holds the result register; the cell store
// write port and the pose registers are updated once per request.
// Reset: pose returns to the start pose, registers to their defaults, and per-cell valid
// flags clear at once, so the store reads as unvisited with no clearing pass.
`timescale 1ns / 1ps
`include "maze_cell_explorer_unit_defines.svh"

module maze_cell_explorer_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  cmex_pkg::addr_t  paddr,
	input  cmex_pkg::data_t  pwdata,
	output cmex_pkg::data_t  prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  cmex_pkg::dist_t  front_dist,
	input  cmex_pkg::dist_t  left_dist,
	input  cmex_pkg::dist_t  right_dist,
	output logic             out_valid,
	input  logic             out_stall,
	output cmex_pkg::move_t  move_taken,
	output cmex_pkg::coord_t pos_x_out,
	output cmex_pkg::coord_t pos_y_out,
	output cmex_pkg::head_t  heading_out,
	output logic             cell_was_new,
	output logic             edge_blocked
);
	import cmex_pkg::*;

	cfg_t   cfg;
	step_t  res;

	logic   vld_s1;
	dist_t  fd_s1;
	dist_t  ld_s1;
	dist_t  rd_s1;

	logic   vld_s2;
	move_t  move_s2;
	coord_t x_s2;
	coord_t y_s2;
	head_t  head_s2;
	logic   new_s2;
	logic   blk_s2;

	coord_t pos_x_q;
	coord_t pos_y_q;
	head_t  head_q;
	coord_t pos_x_d;
	coord_t pos_y_d;
	head_t  head_d;

	logic [CELLS-1:0] cell_vld_q;
	logic   fwd_q;
	cell_t  fwd_cell_q;
	cell_t  ram_rdata;
	cell_t  cell_in;
	cidx_t  cur_idx;
	cidx_t  rd_idx;

	logic   adv;
	logic   proc;
	logic   in_take;

	logic   pos_ok;
	logic   pose_held;
	logic   same_cell;

	cmex_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv = !vld_s2 || !out_stall;
	assign proc = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			fd_s1 <= front_dist;
			ld_s1 <= left_dist;
			rd_s1 <= right_dist;
		end
	end

	// The store is read at the pose of the next cycle; a write to that same cell is forwarded.
	assign cur_idx = cell_idx(pos_x_q, pos_y_q);
	assign rd_idx = cell_idx(pos_x_d, pos_y_d);

	cmex_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (proc),
		.waddr (cur_idx),
		.wdata (res.cell_nxt),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (!cell_vld_q[cur_idx]) begin
			cell_in = '0;
		end else if (fwd_q) begin
			cell_in = fwd_cell_q;
		end else begin
			cell_in = ram_rdata;
		end
	end

	cmex_step u_step (
		.cell_in    (cell_in),
		.front_dist (fd_s1),
		.left_dist  (ld_s1),
		.right_dist (rd_s1),
		.thresh     (cfg.thresh),
		.pos_x      (pos_x_q),
		.pos_y      (pos_y_q),
		.heading    (head_q),
		.res        (res)
	);

	always_comb begin
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		head_d = head_q;
		if (proc) begin
			pos_x_d = res.x;
			pos_y_d = res.y;
			head_d = res.heading;
		end
		if (cfg.ld_x) begin
			pos_x_d = cfg.x;
		end
		if (cfg.ld_y) begin
			pos_y_d = cfg.y;
		end
		if (cfg.ld_h) begin
			head_d = cfg.heading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= POS_X_RST;
			pos_y_q <= POS_Y_RST;
			head_q <= START_H_RST;
			cell_vld_q <= '0;
			fwd_q <= 1'b0;
		end else begin
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
			head_q <= head_d;
			fwd_q <= proc && (cur_idx == rd_idx);
			if (proc) begin
				cell_vld_q[cur_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_cell_q <= res.cell_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (proc) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			move_s2 <= res.move;
			x_s2 <= res.x;
			y_s2 <= res.y;
			head_s2 <= res.heading;
			new_s2 <= res.was_new;
			blk_s2 <= res.blocked;
		end
	end

	assign out_valid = vld_s2;
	assign move_taken = move_s2;
	assign pos_x_out = x_s2;
	assign pos_y_out = y_s2;
	assign heading_out = head_s2;
	assign cell_was_new = new_s2;
	assign edge_blocked = blk_s2;

	assign pos_ok = (int'(pos_x_q) < USE_W) && (int'(pos_y_q) < USE_H);
	assign pose_held = (res.x == pos_x_q) && (res.y == pos_y_q) && (res.heading == head_q);
	assign same_cell = proc && (cur_idx == rd_idx);

	`CMEX_ASSERT_NOW(a_pos_in_grid, 1'b1, pos_ok, "pose left the usable grid")
	`CMEX_ASSERT_NOW(a_blocked_holds, vld_s1 && res.blocked, pose_held, "refused move changed the pose")
	`CMEX_ASSERT_NOW(a_blocked_has_move, vld_s2 && blk_s2, move_s2 != MOVE_NONE, "refused move unnamed")
	`CMEX_ASSERT_NOW(a_write_visited, proc, res.cell_nxt[VIS_BIT], "cell written back unvisited")
	`CMEX_ASSERT_NEXT(a_fwd_valid, same_cell, fwd_q && cell_vld_q[cur_idx], "forwarded cell not valid")

endmodule

[hdl/cmex_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cmex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/cmex_cfg.sv]
// APB register file holding the threshold and start pose registers.
`timescale 1ns / 1ps

module cmex_cfg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  cmex_pkg::addr_t paddr,
	input  cmex_pkg::data_t pwdata,
	output cmex_pkg::data_t prdata,
	output logic           pready,
	output cmex_pkg::cfg_t cfg
);
	import cmex_pkg::*;

	dist_t    thresh_q;
	coord_t   sx_q;
	coord_t   sy_q;
	head_t    sh_q;
	logic     wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			sx_q <= coord_t'(START_X_RST);
			sy_q <= coord_t'(START_Y_RST);
			sh_q <= START_H_RST;
		end else if (wr) begin
			unique case (idx)
				REG_THRESH:  thresh_q <= pwdata[11:0];
				REG_START_X: sx_q <= pwdata[2:0];
				REG_START_Y: sy_q <= pwdata[2:0];
				REG_START_H: sh_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESH:  prdata = data_t'(thresh_q);
			REG_START_X: prdata = data_t'(sx_q);
			REG_START_Y: prdata = data_t'(sy_q);
			REG_START_H: prdata = data_t'(sh_q);
			default:     prdata = '0;
		endcase
	end

	// A written start coordinate is saturated to the last usable column or row.
	always_comb begin
		cfg.thresh = thresh_q;
		cfg.ld_x = wr && (idx == REG_START_X);
		cfg.ld_y = wr && (idx == REG_START_Y);
		cfg.ld_h = wr && (idx == REG_START_H);
		cfg.x = (int'(pwdata[2:0]) < USE_W) ? pwdata[2:0] : coord_t'(USE_W - 1);
		cfg.y = (int'(pwdata[2:0]) < USE_H) ? pwdata[2:0] : coord_t'(USE_H - 1);
		cfg.heading = pwdata[1:0];
	end

endmodule

[hdl/cmex_step.sv]
// Cell update and move choice for one request at the current position.
`timescale 1ns / 1ps

module cmex_step (
	input  cmex_pkg::cell_t  cell_in,
	input  cmex_pkg::dist_t  front_dist,
	input  cmex_pkg::dist_t  left_dist,
	input  cmex_pkg::dist_t  right_dist,
	input  cmex_pkg::dist_t  thresh,
	input  cmex_pkg::coord_t pos_x,
	input  cmex_pkg::coord_t pos_y,
	input  cmex_pkg::head_t  heading,
	output cmex_pkg::step_t  res
);
	import cmex_pkg::*;

	side_t  sides [4];
	logic   was_new;
	logic   found;
	head_t  sel_dir;
	head_t  dir;
	head_t  rel;
	move_t  move;
	logic   off_grid;
	coord_t nx;
	coord_t ny;

	assign was_new = !cell_in[VIS_BIT];

	always_comb begin
		found = 1'b0;
		sel_dir = heading;
		move = MOVE_NONE;
		dir = heading;
		rel = REL_FWD;
		for (int d = 0; d < 4; d++) begin
			sides[d] = cell_in[SIDE_LSB + 2 * d +: 2];
			if (was_new) begin
				rel = head_t'(d) - heading;
				unique case (rel)
					REL_FWD:   sides[d] = (front_dist > thresh) ? SIDE_GAP : SIDE_WALL;
					REL_RIGHT: sides[d] = (right_dist > thresh) ? SIDE_GAP : SIDE_WALL;
					REL_LEFT:  sides[d] = (left_dist > thresh) ? SIDE_GAP : SIDE_WALL;
					REL_BACK:  sides[d] = SIDE_GAP;
					default:   sides[d] = SIDE_WALL;
				endcase
			end
		end
		// Try forward, right, left and back in that order.
		for (int k = 0; k < 4; k++) begin
			dir = heading + REL_ORDER[k];
			if (!found && sides[dir] == SIDE_GAP) begin
				found = 1'b1;
				sel_dir = dir;
				move = move_t'(3'(k));
			end
		end
		if (found) begin
			sides[sel_dir] = SIDE_USED;
		end
	end

	always_comb begin
		nx = pos_x;
		ny = pos_y;
		off_grid = 1'b0;
		unique case (sel_dir)
			DIR_N: begin
				off_grid = (pos_y == coord_t'(USE_H - 1));
				ny = pos_y + 3'd1;
			end
			DIR_E: begin
				off_grid = (pos_x == coord_t'(USE_W - 1));
				nx = pos_x + 3'd1;
			end
			DIR_S: begin
				off_grid = (pos_y == '0);
				ny = pos_y - 3'd1;
			end
			DIR_W: begin
				off_grid = (pos_x == '0);
				nx = pos_x - 3'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.cell_nxt = {sides[3], sides[2], sides[1], sides[0], 1'b1};
		res.move = move;
		res.was_new = was_new;
		res.blocked = found && off_grid;
		if (found && !off_grid) begin
			res.x = nx;
			res.y = ny;
			res.heading = sel_dir;
		end else begin
			res.x = pos_x;
			res.y = pos_y;
			res.heading = heading;
		end
	end

endmodule
